### rtl/line_pixel_rasterizer_defines.svh
// Assertion macros used by the checker file of the line rasterizer
`ifndef LINE_PIXEL_RASTERIZER_DEFINES_SVH
`define LINE_PIXEL_RASTERIZER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define LPR_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define LPR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also runs through reset
`define LPR_ASSERT_NEXT_ALWAYS(name, clk, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/lpr_pkg.sv
// Shared types and constants of the line rasterizer
package lpr_pkg;

  localparam int CoordBits  = 12;
  localparam int ScreenW    = 320;
  localparam int ScreenH    = 200;
  localparam int AddrBits   = 20;
  localparam int ColorBits  = 8;
  localparam int CfgDataW   = 32;
  localparam int ApbAddrW   = 3;

  // input tdata layout, lowest bit first
  localparam int InSxLsb     = 0;
  localparam int InSyLsb     = CoordBits;
  localparam int InExLsb     = 2 * CoordBits;
  localparam int InEyLsb     = 3 * CoordBits;
  localparam int InColorLsb  = 4 * CoordBits;
  localparam int InFieldBits = 4 * CoordBits + ColorBits;
  localparam int InDataW     = ((InFieldBits + 7) / 8) * 8;

  localparam int OutFieldBits = 2 * CoordBits + AddrBits + ColorBits;
  localparam int OutDataW     = ((OutFieldBits + 7) / 8) * 8;

  // request queue, power of two
  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

  // register index, taken from paddr[2]
  localparam logic RegIdxFrameBase = 1'b0;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [CoordBits-1:0]        delta_t;
  typedef logic [CoordBits:0]          count_t;
  typedef logic signed [1:0]           dir_t;
  typedef logic [AddrBits-1:0]         addr_t;
  typedef logic [ColorBits-1:0]        color_t;

  // classified request, front to back
  typedef struct packed {
    cmd_t   kind;
    coord_t x0;
    coord_t y0;
    logic   x_major;
    dir_t   step_x;
    dir_t   step_y;
    delta_t major;
    delta_t minor;
    color_t color;
  } line_req_t;

  // pixel from the walker, address not yet summed
  typedef struct packed {
    coord_t x;
    coord_t y;
    addr_t  y_scaled;
    color_t color;
    logic   on_screen;
    logic   last;
  } pix_t;

  // finished result
  typedef struct packed {
    coord_t x;
    coord_t y;
    addr_t  address;
    color_t color;
    logic   on_screen;
    logic   last;
  } pix_out_t;

endpackage

### rtl/lpr_front.sv
// Front end: takes requests, works out deltas and classifies the line
module lpr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpr_pkg::cmd_t       in_cmd,
  input  lpr_pkg::coord_t     in_sx,
  input  lpr_pkg::coord_t     in_sy,
  input  lpr_pkg::coord_t     in_ex,
  input  lpr_pkg::coord_t     in_ey,
  input  lpr_pkg::color_t     in_color,
  output logic                push_valid,
  input  logic                push_ready,
  output lpr_pkg::line_req_t  push_data
);
  import lpr_pkg::*;

  logic                      a_valid;
  cmd_t                      a_cmd;
  coord_t                    a_sx, a_sy, a_ex, a_ey;
  color_t                    a_color;
  logic signed [CoordBits:0] a_dx, a_dy;

  logic                      accept;
  logic signed [CoordBits:0] neg_dx, neg_dy;
  delta_t                    ax, ay;
  logic                      x_major;

  assign in_ready = !a_valid || push_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (push_ready) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_cmd   <= in_cmd;
      a_sx    <= in_sx;
      a_sy    <= in_sy;
      a_ex    <= in_ex;
      a_ey    <= in_ey;
      a_color <= in_color;
      a_dx    <= (CoordBits+1)'(in_ex) - (CoordBits+1)'(in_sx);
      a_dy    <= (CoordBits+1)'(in_ey) - (CoordBits+1)'(in_sy);
    end
  end

  // |delta| always fits the coordinate width unsigned
  assign neg_dx  = -a_dx;
  assign neg_dy  = -a_dy;
  assign ax      = a_dx[CoordBits] ? neg_dx[CoordBits-1:0] : a_dx[CoordBits-1:0];
  assign ay      = a_dy[CoordBits] ? neg_dy[CoordBits-1:0] : a_dy[CoordBits-1:0];
  assign x_major = ax > ay;

  assign push_valid = a_valid;

  always_comb begin
    push_data         = '0;
    push_data.kind    = a_cmd;
    push_data.color   = a_color;
    push_data.x_major = x_major;
    push_data.major   = x_major ? ax : ay;
    push_data.minor   = x_major ? ay : ax;
    priority if (a_dx == '0) begin
      // vertical: walk up from the lower y
      push_data.x0     = a_sx;
      push_data.y0     = (a_sy < a_ey) ? a_sy : a_ey;
      push_data.step_x = 2'sd0;
      push_data.step_y = 2'sd1;
    end else if (a_dy == '0) begin
      // horizontal: walk right from the lower x
      push_data.x0     = (a_sx < a_ex) ? a_sx : a_ex;
      push_data.y0     = a_sy;
      push_data.step_x = 2'sd1;
      push_data.step_y = 2'sd0;
    end else begin
      push_data.x0     = a_sx;
      push_data.y0     = a_sy;
      push_data.step_x = a_dx[CoordBits] ? -2'sd1 : 2'sd1;
      push_data.step_y = a_dy[CoordBits] ? -2'sd1 : 2'sd1;
    end
  end

endmodule

### rtl/lpr_queue.sv
// Short request queue between front and back
module lpr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  lpr_pkg::line_req_t  push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output lpr_pkg::line_req_t  pop_data
);
  import lpr_pkg::*;

  line_req_t            slots [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr, rd_ptr;
  logic [QueueAw:0]     count;
  logic                 do_push, do_pop;

  assign push_ready = count != (QueueAw+1)'(QueueDepth);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/lpr_back.sv
// Back end: holds the line state and walks one pixel per step request
module lpr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  lpr_pkg::line_req_t  req,
  output logic                pix_valid,
  input  logic                pix_ready,
  output lpr_pkg::pix_t       pix
);
  import lpr_pkg::*;

  localparam addr_t ScreenWAddr = AddrBits'(ScreenW);

  logic   busy;
  coord_t cur_x, cur_y;
  count_t error_acc;
  count_t pixels_left;
  logic   x_major;
  dir_t   step_x, step_y;
  delta_t major_delta, minor_delta;
  color_t line_color;

  logic   fire, do_start, do_emit;
  logic   last;
  count_t err_sum, err_next;
  logic   minor_hit;
  coord_t x_next, y_next;
  addr_t  y_ext;
  logic   vis;

  assign req_ready = !pix_valid || pix_ready;
  assign fire      = req_valid && req_ready;
  assign do_start  = fire && (req.kind == CMD_START);
  // step while idle is swallowed
  assign do_emit   = fire && (req.kind == CMD_STEP) && busy;

  assign last      = pixels_left <= count_t'(1);
  assign err_sum   = error_acc + count_t'(minor_delta);
  assign minor_hit = err_sum >= count_t'(major_delta);
  assign err_next  = minor_hit ? err_sum - count_t'(major_delta) : err_sum;

  always_comb begin
    if (x_major) begin
      x_next = cur_x + coord_t'(step_x);
      y_next = minor_hit ? cur_y + coord_t'(step_y) : cur_y;
    end else begin
      x_next = minor_hit ? cur_x + coord_t'(step_x) : cur_x;
      y_next = cur_y + coord_t'(step_y);
    end
  end

  assign y_ext = AddrBits'(cur_y);
  assign vis   = (cur_x >= 0) && (int'(cur_x) < ScreenW) &&
                 (cur_y >= 0) && (int'(cur_y) < ScreenH);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pix_valid <= 1'b0;
    end else begin
      if (do_start) begin
        busy <= 1'b1;
      end else if (do_emit && last) begin
        busy <= 1'b0;
      end
      if (do_emit) begin
        pix_valid <= 1'b1;
      end else if (pix_ready) begin
        pix_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      cur_x       <= req.x0;
      cur_y       <= req.y0;
      x_major     <= req.x_major;
      step_x      <= req.step_x;
      step_y      <= req.step_y;
      major_delta <= req.major;
      minor_delta <= req.minor;
      line_color  <= req.color;
      error_acc   <= count_t'(req.major >> 1);
      pixels_left <= count_t'(req.major) + 1'b1;
    end else if (do_emit) begin
      cur_x       <= x_next;
      cur_y       <= y_next;
      error_acc   <= err_next;
      pixels_left <= last ? '0 : pixels_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      pix.x         <= cur_x;
      pix.y         <= cur_y;
      pix.y_scaled  <= y_ext * ScreenWAddr;
      pix.color     <= line_color;
      pix.on_screen <= vis;
      pix.last      <= last;
    end
  end

endmodule

### rtl/lpr_emit.sv
// Output stage: frame address sum and the result register
module lpr_emit (
  input  logic               clk,
  input  logic               rst,
  input  lpr_pkg::addr_t     frame_base,
  input  logic               pix_valid,
  output logic               pix_ready,
  input  lpr_pkg::pix_t      pix,
  output logic               out_valid,
  input  logic               out_ready,
  output lpr_pkg::pix_out_t  out_pix
);
  import lpr_pkg::*;

  logic load;

  assign pix_ready = !out_valid || out_ready;
  assign load      = pix_valid && pix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // negative x wraps through sign extension, sum is modulo 2^AddrBits
  always_ff @(posedge clk) begin
    if (load) begin
      out_pix.x         <= pix.x;
      out_pix.y         <= pix.y;
      out_pix.address   <= frame_base + pix.y_scaled + AddrBits'(pix.x);
      out_pix.color     <= pix.color;
      out_pix.on_screen <= pix.on_screen;
      out_pix.last      <= pix.last;
    end
  end

endmodule

### rtl/line_pixel_rasterizer.sv
// Top level of the line rasterizer: stream ports, register port, unit hookup
//
//  channel   | dir | handshake                  | payload
//  ----------+-----+----------------------------+-------------------------------------
//  s_axis    | in  | tvalid/tready              | tuser: cmd; tdata: line endpoints, color
//  m_axis    | out | tvalid/tready              | tdata: pixel x, y, address, color;
//            |     |                            | tuser: on_screen; tlast: last pixel
//  apb       | in  | psel/penable, pready=1     | frame_base at byte address 0
//
//  Throughput: one request per clock sustained, one pixel per clock per step request.
//  Path: a step request passes the front register, a queue slot, the walker register
//  and the address/output register, in that order, before its pixel shows.
//  Reset: synchronous; clears valids, queue pointers, busy and frame_base.
//  Stalls: m_axis_tready low holds the output register; requests keep flowing
//  into the queue until it and the front register are full, then s_axis_tready drops.
module line_pixel_rasterizer (
  input  logic                              clk,
  input  logic                              rst,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lpr_pkg::InDataW-1:0]       s_axis_tdata,  // start_x, start_y, end_x, end_y, pen_color
  input  logic [0:0]                        s_axis_tuser,  // cmd
  // pixel stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [lpr_pkg::OutDataW-1:0]      m_axis_tdata,  // pixel_x, pixel_y, pixel_address, pixel_color, zero pad
  output logic [0:0]                        m_axis_tuser,  // on_screen
  output logic                              m_axis_tlast,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lpr_pkg::ApbAddrW-1:0]      paddr,
  input  logic [lpr_pkg::CfgDataW-1:0]      pwdata,
  output logic [lpr_pkg::CfgDataW-1:0]      prdata,
  output logic                              pready
);
  import lpr_pkg::*;

  addr_t     frame_base;
  logic      reg_sel;

  logic      push_valid, push_ready;
  line_req_t push_data;
  logic      pop_valid, pop_ready;
  line_req_t pop_data;
  logic      pix_valid, pix_ready;
  pix_t      pix;
  pix_out_t  out_pix;

  // ---------------- register port ----------------
  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == RegIdxFrameBase;
  assign prdata  = reg_sel ? CfgDataW'(frame_base) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      frame_base <= pwdata[AddrBits-1:0];
    end
  end

  // ---------------- front: capture and classify ----------------
  lpr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (cmd_t'(s_axis_tuser[0])),
    .in_sx      (coord_t'(s_axis_tdata[InSxLsb +: CoordBits])),
    .in_sy      (coord_t'(s_axis_tdata[InSyLsb +: CoordBits])),
    .in_ex      (coord_t'(s_axis_tdata[InExLsb +: CoordBits])),
    .in_ey      (coord_t'(s_axis_tdata[InEyLsb +: CoordBits])),
    .in_color   (s_axis_tdata[InColorLsb +: ColorBits]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // ---------------- decoupling queue ----------------
  lpr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // ---------------- back: Bresenham walker ----------------
  lpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .req_valid (pop_valid),
    .req_ready (pop_ready),
    .req       (pop_data),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix)
  );

  // ---------------- address sum and output register ----------------
  lpr_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .frame_base (frame_base),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix        (pix),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_pix    (out_pix)
  );

  assign m_axis_tdata = OutDataW'({out_pix.color, out_pix.address, out_pix.y, out_pix.x});
  assign m_axis_tuser = out_pix.on_screen;
  assign m_axis_tlast = out_pix.last;

endmodule

### rtl/lpr_checker.sv
// Port-level checks of the line rasterizer, bound to the top level
`include "line_pixel_rasterizer_defines.svh"

module lpr_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [lpr_pkg::OutDataW-1:0]      m_axis_tdata,
  input logic [0:0]                        m_axis_tuser,
  input logic                              m_axis_tlast,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic                              pready,
  input logic [lpr_pkg::ApbAddrW-1:0]      paddr,
  input logic [lpr_pkg::CfgDataW-1:0]      pwdata,
  input logic [lpr_pkg::CfgDataW-1:0]      prdata
);
  import lpr_pkg::*;

  coord_t px, py;
  logic   vis;
  logic   base_write;
  logic   stalled;

  assign px         = coord_t'(m_axis_tdata[CoordBits-1:0]);
  assign py         = coord_t'(m_axis_tdata[2*CoordBits-1:CoordBits]);
  assign vis        = (px >= 0) && (int'(px) < ScreenW) && (py >= 0) && (int'(py) < ScreenH);
  assign base_write = psel && penable && pwrite && pready && (paddr[2] == RegIdxFrameBase);
  assign stalled    = m_axis_tvalid && !m_axis_tready;

  // a held pixel keeps all its fields
  `LPR_ASSERT_NEXT(a_out_hold, clk, rst, stalled, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "pixel changed while stalled")

  // on-screen flag agrees with the reported coordinates
  `LPR_ASSERT_NOW(a_vis_flag, clk, rst, m_axis_tvalid, m_axis_tuser[0] == vis, "on_screen flag disagrees with x/y")

  // base register reads back what was written
  `LPR_ASSERT_NEXT(a_base_rdback, clk, rst, base_write, paddr[2] != RegIdxFrameBase || prdata[AddrBits-1:0] == $past(pwdata[AddrBits-1:0]), "frame_base readback mismatch")

  // reset leaves no result pending
  `LPR_ASSERT_NEXT_ALWAYS(a_rst_empty, clk, rst, !m_axis_tvalid, "result valid right after reset")

endmodule

bind line_pixel_rasterizer lpr_checker u_lpr_checker (.*);
